### rtl/coap_message_parser_macros.svh
// Assertion macros for the CoAP message parser
`ifndef COAP_MESSAGE_PARSER_MACROS_SVH
`define COAP_MESSAGE_PARSER_MACROS_SVH
// assert a property at each clock edge outside reset
`define CMP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assert that a condition in one cycle implies another in the next cycle
`define CMP_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);
`endif

### rtl/cmp_pkg.sv
// ----------------------------------------------------------------------------
// cmp_pkg
// Types and constants shared by the CoAP message parser modules.
// ----------------------------------------------------------------------------
package cmp_pkg;
    localparam logic [2:0] CLS_HEADER = 3'd0;
    localparam logic [2:0] CLS_TOKEN  = 3'd1;
    localparam logic [2:0] CLS_OPT    = 3'd2;
    localparam logic [2:0] CLS_VALUE  = 3'd3;
    localparam logic [2:0] CLS_MARKER = 3'd4;
    localparam logic [2:0] CLS_PAY    = 3'd5;
    localparam logic [2:0] CLS_IGNORE = 3'd6;
    localparam logic [2:0] CLS_ERROR  = 3'd7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_HDR_SHORT = 3'd1;
    localparam logic [2:0] ST_BAD_VER   = 3'd2;
    localparam logic [2:0] ST_TOKEN_BAD = 3'd3;
    localparam logic [2:0] ST_OPT_SHORT = 3'd4;
    localparam logic [2:0] ST_DELTA15   = 3'd5;
    localparam logic [2:0] ST_LEN15     = 3'd6;
    localparam logic [2:0] ST_OPT_BIG   = 3'd7;

    localparam logic [7:0] MARKER = 8'hFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  byte_class;
        logic [7:0]  echo_byte;
        logic [15:0] option_number;
        logic [15:0] option_length;
        logic [4:0]  option_index;
        logic [1:0]  msg_type;
        logic [7:0]  msg_code;
        logic [15:0] msg_id;
        logic [3:0]  token_length;
        logic [2:0]  status;
        logic        done_res;
    } t_out_item;
endpackage

### rtl/cmp_if.sv
// ----------------------------------------------------------------------------
// cmp_in_if / cmp_out_if
// Valid/ready channels for the parser's byte input and result output.
// ----------------------------------------------------------------------------
interface cmp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;
    modport source (output valid, in_byte, last_byte, input ready);
    modport sink (input valid, in_byte, last_byte, output ready);
endinterface

interface cmp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_class;
    logic [7:0]  echo_byte;
    logic [15:0] option_number;
    logic [15:0] option_length;
    logic [4:0]  option_index;
    logic [1:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] msg_id;
    logic [3:0]  token_length;
    logic [2:0]  status;
    logic        done_res;
    modport source (output valid, byte_class, echo_byte, option_number, option_length,
        option_index, msg_type, msg_code, msg_id, token_length, status, done_res,
        input ready);
    modport sink (input valid, byte_class, echo_byte, option_number, option_length,
        option_index, msg_type, msg_code, msg_id, token_length, status, done_res,
        output ready);
endinterface

### rtl/cmp_queue.sv
// ----------------------------------------------------------------------------
// cmp_queue
// Two-entry queue that parts the input channel from the parsing engine.
// ----------------------------------------------------------------------------
module cmp_queue
    import cmp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_data,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_empty,
    output t_in_item o_data
);
    t_in_item   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

### rtl/cmp_engine.sv
// ----------------------------------------------------------------------------
// cmp_engine
// Per-byte CoAP parse state machine with a registered result stage.
// ----------------------------------------------------------------------------
module cmp_engine
    import cmp_pkg::*;
#(
    parameter int MaxOptions = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [4:0] i_max_options,
    input  logic      i_have,
    input  t_in_item  i_item,
    output logic      o_take,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_TOKEN   = 3'd1;
    localparam logic [2:0] PH_OPTHEAD = 3'd2;
    localparam logic [2:0] PH_DEXT    = 3'd3;
    localparam logic [2:0] PH_LEXT    = 3'd4;
    localparam logic [2:0] PH_VALUE   = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;
    localparam logic [2:0] PH_IGNORE  = 3'd7;
    localparam int OW = $clog2(MaxOptions + 1) > 5 ? $clog2(MaxOptions + 1) : 5;
    localparam logic [OW-1:0] LimCap = OW'(MaxOptions);

    logic [2:0]  r_ph, n_ph;
    logic [1:0]  r_hp, n_hp, r_ver, n_ver, r_typ, n_typ;
    logic [3:0]  r_tl, n_tl, r_tleft, n_tleft, r_pln, n_pln;
    logic [7:0]  r_code, n_code;
    logic [15:0] r_id, n_id, r_run, n_run, r_acc, n_acc, r_vleft, n_vleft;
    logic [OW-1:0] r_os, n_os;
    logic [2:0]  r_st, n_st;
    logic        r_eleft, n_eleft;
    logic        r_e269, n_e269;
    logic [15:0] r_cnum, n_cnum, r_clen, n_clen;
    logic        r_ov;
    t_out_item   r_out;
    logic [2:0]  cls;
    logic [OW-1:0] limit;
    logic [7:0]  b;
    logic [3:0]  dn;
    logic [15:0] ev;

    assign o_take  = i_have && (!r_ov || i_ready);
    assign o_valid = r_ov;
    assign o_item  = r_out;
    assign b       = i_item.in_byte;
    assign dn      = b[7:4];
    assign limit   = (OW'(i_max_options) < LimCap) ? OW'(i_max_options) : LimCap;
    assign ev      = {r_acc[7:0], b} + (r_e269 ? 16'd269 : 16'd13);

    always_comb begin
        n_ph = r_ph; n_hp = r_hp; n_ver = r_ver; n_typ = r_typ; n_tl = r_tl;
        n_code = r_code; n_id = r_id; n_tleft = r_tleft; n_run = r_run;
        n_acc = r_acc; n_pln = r_pln; n_vleft = r_vleft; n_os = r_os;
        n_st = r_st; n_eleft = r_eleft; n_e269 = r_e269; n_cnum = r_cnum;
        n_clen = r_clen;
        cls = CLS_ERROR;
        if (r_st == ST_OK) begin
            unique case (r_ph)
                PH_HEADER: begin
                    cls = CLS_HEADER;
                    unique case (r_hp)
                        2'd0: begin
                            n_ver = b[7:6]; n_typ = b[5:4]; n_tl = b[3:0];
                        end
                        2'd1: n_code = b;
                        2'd2: n_id = {b, 8'd0};
                        default: n_id = r_id | {8'd0, b};
                    endcase
                    if (r_hp == 2'd3) begin
                        if (r_ver != 2'd1) n_st = ST_BAD_VER;
                        else if (r_tl > 4'd8) n_st = ST_TOKEN_BAD;
                        else if (r_tl == 4'd0) n_ph = PH_OPTHEAD;
                        else begin
                            n_tleft = r_tl; n_ph = PH_TOKEN;
                        end
                    end else begin
                        n_hp = r_hp + 2'd1;
                    end
                end
                PH_TOKEN: begin
                    cls = CLS_TOKEN;
                    n_tleft = r_tleft - 4'd1;
                    if (r_tleft <= 4'd1) n_ph = PH_OPTHEAD;
                end
                PH_OPTHEAD: begin
                    if (b == MARKER) begin
                        cls = CLS_MARKER; n_ph = PH_PAYLOAD;
                    end else if (r_os >= limit) begin
                        cls = CLS_IGNORE; n_ph = PH_IGNORE;
                    end else begin
                        cls = CLS_OPT;
                        n_pln = b[3:0]; n_cnum = r_run; n_clen = 16'd0;
                        if (dn == 4'd15) n_st = ST_DELTA15;
                        else if (dn >= 4'd13) begin
                            n_eleft = (dn == 4'd14); n_e269 = (dn == 4'd14);
                            n_acc = 16'd0; n_ph = PH_DEXT;
                        end else begin
                            n_cnum = r_run + {12'd0, dn}; n_run = n_cnum;
                            if (b[3:0] == 4'd15) n_st = ST_LEN15;
                            else if (b[3:0] >= 4'd13) begin
                                n_eleft = (b[3:0] == 4'd14); n_e269 = (b[3:0] == 4'd14);
                                n_acc = 16'd0; n_ph = PH_LEXT;
                            end else begin
                                n_clen = {12'd0, b[3:0]}; n_vleft = n_clen;
                                if (b[3:0] == 4'd0) begin
                                    n_os = r_os + OW'(1); n_ph = PH_OPTHEAD;
                                end else n_ph = PH_VALUE;
                            end
                        end
                    end
                end
                PH_DEXT, PH_LEXT: begin
                    cls = CLS_OPT;
                    n_acc = {r_acc[7:0], b};
                    n_eleft = 1'b0;
                    if (!r_eleft) begin
                        if (r_ph == PH_DEXT) begin
                            n_cnum = r_run + ev; n_run = n_cnum;
                            if (r_pln == 4'd15) n_st = ST_LEN15;
                            else if (r_pln >= 4'd13) begin
                                n_eleft = (r_pln == 4'd14); n_e269 = (r_pln == 4'd14);
                                n_acc = 16'd0; n_ph = PH_LEXT;
                            end else begin
                                n_clen = {12'd0, r_pln}; n_vleft = n_clen;
                                if (r_pln == 4'd0) begin
                                    n_os = r_os + OW'(1); n_ph = PH_OPTHEAD;
                                end else n_ph = PH_VALUE;
                            end
                        end else begin
                            n_clen = ev; n_vleft = ev;
                            if (ev == 16'd0) begin
                                n_os = r_os + OW'(1); n_ph = PH_OPTHEAD;
                            end else n_ph = PH_VALUE;
                        end
                    end
                end
                PH_VALUE: begin
                    cls = CLS_VALUE;
                    n_vleft = r_vleft - 16'd1;
                    if (r_vleft <= 16'd1) begin
                        n_vleft = 16'd0; n_os = r_os + OW'(1); n_ph = PH_OPTHEAD;
                    end
                end
                PH_PAYLOAD: cls = CLS_PAY;
                default: cls = CLS_IGNORE;
            endcase
        end
        if (i_item.last_byte && n_st == ST_OK) begin
            if (n_ph == PH_HEADER) n_st = ST_HDR_SHORT;
            else if (n_ph == PH_TOKEN) n_st = ST_TOKEN_BAD;
            else if (n_ph == PH_DEXT || n_ph == PH_LEXT) n_st = ST_OPT_SHORT;
            else if (n_ph == PH_VALUE) n_st = ST_OPT_BIG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out.byte_class    <= cls;
            r_out.echo_byte     <= b;
            r_out.option_number <= n_cnum;
            r_out.option_length <= n_clen;
            r_out.option_index  <= 5'(r_os);
            r_out.msg_type      <= n_typ;
            r_out.msg_code      <= n_code;
            r_out.msg_id        <= n_id;
            r_out.token_length  <= n_tl;
            r_out.status        <= n_st;
            r_out.done_res      <= i_item.last_byte;
        end
        if (!i_rst_n || (o_take && i_item.last_byte)) begin
            r_ph <= PH_HEADER; r_hp <= '0; r_ver <= '0; r_typ <= '0; r_tl <= '0;
            r_code <= '0; r_id <= '0; r_tleft <= '0; r_run <= '0; r_acc <= '0;
            r_pln <= '0; r_vleft <= '0; r_os <= '0; r_st <= ST_OK;
            r_eleft <= 1'b0; r_e269 <= 1'b0; r_cnum <= '0; r_clen <= '0;
        end else if (o_take) begin
            r_ph <= n_ph; r_hp <= n_hp; r_ver <= n_ver; r_typ <= n_typ; r_tl <= n_tl;
            r_code <= n_code; r_id <= n_id; r_tleft <= n_tleft; r_run <= n_run;
            r_acc <= n_acc; r_pln <= n_pln; r_vleft <= n_vleft; r_os <= n_os;
            r_st <= n_st; r_eleft <= n_eleft; r_e269 <= n_e269; r_cnum <= n_cnum;
            r_clen <= n_clen;
        end
        if (!i_rst_n) r_ov <= 1'b0;
        else if (o_take) r_ov <= 1'b1;
        else if (i_ready) r_ov <= 1'b0;
    end
endmodule

### rtl/coap_message_parser.sv
// ----------------------------------------------------------------------------
// coap_message_parser
// Byte-stream CoAP message decoder with per-byte classification and status.
// ----------------------------------------------------------------------------
// One result item per input byte, one byte per cycle sustained while the
// result channel is ready. A two-entry queue buffers input bytes in front
// of the parse engine, which registers each result. The option limit
// register may be changed only between messages.
module coap_message_parser
    import cmp_pkg::*;
#(
    parameter int MAX_OPTIONS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    cmp_in_if.sink     i_in,
    cmp_out_if.source  o_out
);
`include "coap_message_parser_macros.svh"
    logic [4:0] r_max_opt;
    logic       q_full, q_empty, take;
    t_in_item   q_in, q_out;
    t_out_item  res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max_opt <= 5'd16;
        else if (i_cfg_we) r_max_opt <= i_cfg_wdata;
    end

    assign i_in.ready = !q_full;
    assign q_in.in_byte   = i_in.in_byte;
    assign q_in.last_byte = i_in.last_byte;

    cmp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_in.valid && !q_full), .i_data(q_in), .o_full(q_full),
        .i_pop(take), .o_empty(q_empty), .o_data(q_out)
    );

    cmp_engine #(.MaxOptions(MAX_OPTIONS)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_max_options(r_max_opt),
        .i_have(!q_empty), .i_item(q_out), .o_take(take),
        .o_valid(o_out.valid), .i_ready(o_out.ready), .o_item(res)
    );

    assign o_out.byte_class    = res.byte_class;
    assign o_out.echo_byte     = res.echo_byte;
    assign o_out.option_number = res.option_number;
    assign o_out.option_length = res.option_length;
    assign o_out.option_index  = res.option_index;
    assign o_out.msg_type      = res.msg_type;
    assign o_out.msg_code      = res.msg_code;
    assign o_out.msg_id        = res.msg_id;
    assign o_out.token_length  = res.token_length;
    assign o_out.status        = res.status;
    assign o_out.done_res      = res.done_res;

    `CMP_ASSERT(a_no_pop_empty, i_clk, i_rst_n, take |-> !q_empty, "pop from empty queue")
    `CMP_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, o_out.valid && !o_out.ready, o_out.valid, "result dropped")
    `CMP_ASSERT_NEXT(a_hold_byte, i_clk, i_rst_n, o_out.valid && !o_out.ready, $stable(o_out.echo_byte), "result changed")
    `CMP_ASSERT(a_err_class, i_clk, i_rst_n, (o_out.valid && o_out.byte_class == CLS_ERROR) |-> (o_out.status != ST_OK), "error class with ok status")
endmodule

### sim/coap_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coap_parser_checker
// Watches the byte and result channels of the CoAP message parser, predicts
// each result from its own model of the decoder and compares field by field.
// ----------------------------------------------------------------------------
module coap_parser_checker
    import cmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    cmp_in_if          in_mon,
    cmp_out_if         out_mon,
    output int         o_errors,
    output int         o_pending,
    output int         o_messages
);
    localparam int OPT_CAP = 16;

    typedef enum logic [2:0] {
        P_HEADER, P_TOKEN, P_OPTHEAD, P_DEXT, P_LEXT, P_VALUE, P_PAYLOAD, P_IGNORE
    } t_parse_phase;

    t_parse_phase phase;
    logic [4:0]   opt_limit_reg;
    logic [1:0]   hdr_pos;
    logic [1:0]   ver;
    logic [1:0]   mtype;
    logic [3:0]   tkl;
    logic [7:0]   code;
    logic [15:0]  mid;
    logic [3:0]   tok_left;
    logic [15:0]  run_num;
    logic [15:0]  ext_acc;
    logic [3:0]   len_nib;
    logic [15:0]  val_left;
    logic [4:0]   opt_count;
    logic [2:0]   stat;
    logic [1:0]   ext_left;
    logic [15:0]  ext_add;
    logic [15:0]  cur_num;
    logic [15:0]  cur_len;

    t_out_item expected_results[$];
    int        errors;
    int        messages;

    assign o_errors   = errors;
    assign o_pending  = expected_results.size();
    assign o_messages = messages;

    task automatic clear_msg();
        phase = P_HEADER;
        hdr_pos = '0; ver = '0; mtype = '0; tkl = '0; code = '0; mid = '0;
        tok_left = '0; run_num = '0; ext_acc = '0; len_nib = '0; val_left = '0;
        opt_count = '0; stat = ST_OK; ext_left = '0; ext_add = '0;
        cur_num = '0; cur_len = '0;
    endtask

    task automatic start_ext(input logic [3:0] nib, input t_parse_phase nxt);
        ext_left = (nib == 4'd13) ? 2'd1 : 2'd2;
        ext_add  = (nib == 4'd13) ? 16'd13 : 16'd269;
        ext_acc  = '0;
        phase    = nxt;
    endtask

    task automatic close_option();
        opt_count = opt_count + 5'd1;
        phase = P_OPTHEAD;
    endtask

    task automatic take_length(input logic [15:0] len);
        cur_len  = len;
        val_left = len;
        if (len == 16'd0) close_option();
        else phase = P_VALUE;
    endtask

    task automatic take_delta(input logic [15:0] delta);
        cur_num = run_num + delta;
        run_num = cur_num;
        if (len_nib == 4'd15) stat = ST_LEN15;
        else if (len_nib >= 4'd13) start_ext(len_nib, P_LEXT);
        else take_length({12'd0, len_nib});
    endtask

    // Decode one byte and return the result it should produce.
    task automatic decode_byte(input logic [7:0] b, input logic last,
                               output t_out_item res);
        logic [4:0]  idx;
        logic [4:0]  lim;
        logic [2:0]  cls;
        logic [3:0]  dn;
        idx = opt_count;
        lim = (opt_limit_reg < OPT_CAP) ? opt_limit_reg : 5'(OPT_CAP);
        cls = CLS_ERROR;
        if (stat == ST_OK) begin
            case (phase)
                P_HEADER: begin
                    cls = CLS_HEADER;
                    case (hdr_pos)
                        2'd0: begin
                            ver = b[7:6]; mtype = b[5:4]; tkl = b[3:0];
                        end
                        2'd1: code = b;
                        2'd2: mid = {b, 8'd0};
                        default: mid = mid | {8'd0, b};
                    endcase
                    if (hdr_pos == 2'd3) begin
                        if (ver != 2'd1) stat = ST_BAD_VER;
                        else if (tkl > 4'd8) stat = ST_TOKEN_BAD;
                        else if (tkl == 4'd0) phase = P_OPTHEAD;
                        else begin
                            tok_left = tkl;
                            phase = P_TOKEN;
                        end
                    end else begin
                        hdr_pos = hdr_pos + 2'd1;
                    end
                end
                P_TOKEN: begin
                    cls = CLS_TOKEN;
                    if (tok_left > 0) tok_left = tok_left - 4'd1;
                    if (tok_left == 0) phase = P_OPTHEAD;
                end
                P_OPTHEAD: begin
                    if (b == MARKER) begin
                        cls = CLS_MARKER;
                        phase = P_PAYLOAD;
                    end else if (opt_count >= lim) begin
                        cls = CLS_IGNORE;
                        phase = P_IGNORE;
                    end else begin
                        dn = b[7:4];
                        cls = CLS_OPT;
                        len_nib = b[3:0];
                        cur_num = run_num;
                        cur_len = '0;
                        if (dn == 4'd15) stat = ST_DELTA15;
                        else if (dn >= 4'd13) start_ext(dn, P_DEXT);
                        else take_delta({12'd0, dn});
                    end
                end
                P_DEXT, P_LEXT: begin
                    cls = CLS_OPT;
                    ext_acc = {ext_acc[7:0], b};
                    if (ext_left > 0) ext_left = ext_left - 2'd1;
                    if (ext_left == 0) begin
                        if (phase == P_DEXT) take_delta(ext_acc + ext_add);
                        else take_length(ext_acc + ext_add);
                    end
                end
                P_VALUE: begin
                    cls = CLS_VALUE;
                    if (val_left > 0) val_left = val_left - 16'd1;
                    if (val_left == 0) close_option();
                end
                P_PAYLOAD: cls = CLS_PAY;
                default: cls = CLS_IGNORE;
            endcase
        end
        if (last && stat == ST_OK) begin
            case (phase)
                P_HEADER: stat = ST_HDR_SHORT;
                P_TOKEN: stat = ST_TOKEN_BAD;
                P_DEXT, P_LEXT: stat = ST_OPT_SHORT;
                P_VALUE: stat = ST_OPT_BIG;
                default: ;
            endcase
        end
        res.byte_class    = cls;
        res.echo_byte     = b;
        res.option_number = cur_num;
        res.option_length = cur_len;
        res.option_index  = idx;
        res.msg_type      = mtype;
        res.msg_code      = code;
        res.msg_id        = mid;
        res.token_length  = tkl;
        res.status        = stat;
        res.done_res      = last;
        if (last) clear_msg();
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_r;
        t_out_item act_r;
        if (!i_rst_n) begin
            opt_limit_reg = 5'd16;
            clear_msg();
            expected_results.delete();
            errors = 0;
            messages = 0;
        end else begin
            if (i_cfg_we) opt_limit_reg = i_cfg_wdata;
            if (in_mon.valid && in_mon.ready) begin
                decode_byte(in_mon.in_byte, in_mon.last_byte, exp_r);
                expected_results.push_back(exp_r);
                if (in_mon.last_byte) messages++;
            end
            if (out_mon.valid && out_mon.ready) begin
                act_r = '{out_mon.byte_class, out_mon.echo_byte, out_mon.option_number,
                          out_mon.option_length, out_mon.option_index, out_mon.msg_type,
                          out_mon.msg_code, out_mon.msg_id, out_mon.token_length,
                          out_mon.status, out_mon.done_res};
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("result with none expected: byte %h class %0d",
                                 act_r.echo_byte, act_r.byte_class);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (act_r !== exp_r) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch exp/act: cls %0d/%0d byte %h/%h num %h/%h ",
                                      "len %h/%h idx %0d/%0d type %0d/%0d code %h/%h ",
                                      "id %h/%h tkl %0d/%0d st %0d/%0d done %0d/%0d"},
                                     exp_r.byte_class, act_r.byte_class,
                                     exp_r.echo_byte, act_r.echo_byte,
                                     exp_r.option_number, act_r.option_number,
                                     exp_r.option_length, act_r.option_length,
                                     exp_r.option_index, act_r.option_index,
                                     exp_r.msg_type, act_r.msg_type,
                                     exp_r.msg_code, act_r.msg_code,
                                     exp_r.msg_id, act_r.msg_id,
                                     exp_r.token_length, act_r.token_length,
                                     exp_r.status, act_r.status,
                                     exp_r.done_res, act_r.done_res);
                    end
                end
            end
        end
    end
endmodule

### sim/tb_coap_message_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_coap_message_parser
// Feeds directed and random CoAP messages through the parser under several
// option limits, with random stalls on both channels; a checker scores results.
// ----------------------------------------------------------------------------
module tb_coap_message_parser;
    import cmp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_BYTES = 1800;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [4:0] cfg_wdata;
    int         errors;
    int         pending;
    int         messages;
    int         cycles;
    int         bytes_sent;
    bit         no_idle;
    logic [7:0] msg_bytes[$];

    cmp_in_if  in_ch();
    cmp_out_if out_ch();

    coap_message_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    coap_parser_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_messages (messages)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_coap_message_parser: done, errors");
            $finish;
        end
    end

    // Result side: random stalls before each accepted result.
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Leave valid high after the last byte; the next caller drops or reuses it.
    task automatic send_message();
        int gap;
        foreach (msg_bytes[i]) begin
            gap = no_idle ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            in_ch.valid     <= 1'b1;
            in_ch.in_byte   <= msg_bytes[i];
            in_ch.last_byte <= (i == msg_bytes.size() - 1);
            do @(posedge i_clk); while (!in_ch.ready);
            bytes_sent++;
        end
    endtask

    task automatic write_limit(input logic [4:0] value);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (4) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic push_random(input int count);
        repeat (count) msg_bytes.push_back(8'($urandom));
    endtask

    // Mostly well-formed messages with random content; some are corrupted.
    task automatic build_message();
        int tkl;
        int nopt;
        int sel;
        int len;
        int cut;
        msg_bytes.delete();
        tkl = $urandom_range(0, 8);
        msg_bytes.push_back({2'b01, 2'($urandom), 4'(tkl)});
        push_random(3 + tkl);
        nopt = $urandom_range(0, 6);
        repeat (nopt) begin
            logic [3:0] dn;
            logic [3:0] ln;
            sel = $urandom_range(0, 99);
            dn = (sel < 70) ? 4'($urandom_range(0, 12)) : (sel < 85) ? 4'd13 : 4'd14;
            sel = $urandom_range(0, 99);
            ln = (sel < 80) ? 4'($urandom_range(0, 12)) : (sel < 97) ? 4'd13 : 4'd14;
            msg_bytes.push_back({dn, ln});
            if (dn == 4'd13) push_random(1);
            if (dn == 4'd14) push_random(2);
            if (ln == 4'd13) begin
                len = $urandom_range(0, 10);
                msg_bytes.push_back(8'(len));
                len += 13;
            end else if (ln == 4'd14) begin
                len = $urandom_range(0, 20);
                msg_bytes.push_back(8'd0);
                msg_bytes.push_back(8'(len));
                len += 269;
            end else begin
                len = ln;
            end
            push_random(len);
        end
        if ($urandom_range(0, 9) < 6) begin
            msg_bytes.push_back(MARKER);
            push_random($urandom_range(0, 6));
        end
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            cut = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
        end else if (sel < 22) begin
            msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom);
        end else if (sel < 26) begin
            msg_bytes.delete();
            push_random($urandom_range(1, 12));
        end
    endtask

    initial begin
        logic [4:0] limits[6];
        int per_phase;
        limits = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd16, 5'd7};
        cycles = 0;
        bytes_sent = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.in_byte = '0;
        in_ch.last_byte = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: short header, bad version, token errors, nibble 15 cases,
        // truncated extension and value, marker last, and a full message.
        msg_bytes = '{8'h40}; send_message();
        msg_bytes = '{8'h00, 8'h01, 8'h00, 8'h01, 8'h55}; send_message();
        msg_bytes = '{8'h49, 8'h01, 8'h00, 8'h01}; send_message();
        msg_bytes = '{8'h42, 8'h01, 8'h00, 8'h01, 8'hAA}; send_message();
        msg_bytes = '{8'h40, 8'h01, 8'h00, 8'h01, 8'hF0, 8'h00}; send_message();
        msg_bytes = '{8'h40, 8'h01, 8'h00, 8'h01, 8'h1F}; send_message();
        msg_bytes = '{8'h40, 8'h01, 8'h00, 8'h01, 8'hE0, 8'h01}; send_message();
        msg_bytes = '{8'h40, 8'h01, 8'h00, 8'h01, 8'h13, 8'h01}; send_message();
        msg_bytes = '{8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF}; send_message();
        msg_bytes = '{8'h41, 8'h45, 8'h12, 8'h34, 8'hAB, 8'hD1, 8'h05, 8'h11,
                      8'hE0, 8'hFF, 8'hFF, 8'h0D, 8'h00};
        push_random(13);
        msg_bytes.push_back(MARKER);
        msg_bytes.push_back(8'hFF);
        msg_bytes.push_back(8'h00);
        send_message();
        msg_bytes = '{8'h68, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                      8'h20, 8'h40, 8'h80, 8'hFF};
        send_message();

        // Option limit of one: a second option head is ignored, or a marker.
        write_limit(5'd1);
        msg_bytes = '{8'h40, 8'h01, 8'h00, 8'h01, 8'h10, 8'h20, 8'h30}; send_message();
        msg_bytes = '{8'h40, 8'h01, 8'h00, 8'h01, 8'h10, 8'hFF, 8'h99}; send_message();
        write_limit(5'd0);
        msg_bytes = '{8'h40, 8'h01, 8'h00, 8'h01, 8'h10, 8'h20}; send_message();

        per_phase = RANDOM_BYTES / 6;
        foreach (limits[p]) begin
            int target;
            write_limit(limits[p]);
            no_idle = (p == 2);
            target = bytes_sent + per_phase;
            while (bytes_sent < target) begin
                build_message();
                send_message();
            end
        end
        no_idle = 1'b0;

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (10) @(posedge i_clk);
        $display("covered %0d messages, %0d bytes, option limits 0, 1, 3, 7, 16 and 31",
                 messages, bytes_sent);
        if (errors == 0 && pending == 0) begin
            $display("tb_coap_message_parser: done, clean");
        end else begin
            $display("tb_coap_message_parser: done, errors");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/cmp_pkg.sv
rtl/cmp_if.sv
rtl/cmp_queue.sv
rtl/cmp_engine.sv
rtl/coap_message_parser.sv
sim/coap_parser_checker.sv
sim/tb_coap_message_parser.sv
